// ----- hw/rtl/brdl_pkg.sv -----
// ----------------------------------------------------------------------------
// Box region density lookup: shared definitions
// Item layouts, command and register codes and default table sizes.
// ----------------------------------------------------------------------------
package brdl_pkg;

  // Default table sizes.
  localparam int MAX_REGIONS_DEF = 64;
  localparam int MAX_DIMS_DEF    = 4;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_REGION_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIM_COUNT    = 1'd1;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_BOUNDS  = 2'd0;
  localparam logic [1:0] MODE_DENSITY = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  // Density reported when no box contains the point: -1.0 in Q16.16.
  localparam logic signed [31:0] NONE_DENSITY = 32'hFFFF_0000;

  typedef struct packed {
    logic [1:0]         mode;
    logic [5:0]         region_index;
    logic [1:0]         dim_index;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    logic [30:0]        density_value;
    logic signed [31:0] coordinate;
    logic               last_coordinate;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [5:0]         matched_region;
    logic signed [31:0] density;
  } out_item_t;

endpackage

// ----- hw/rtl/brdl_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module brdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/box_region_density_lookup_unit.sv -----
// ----------------------------------------------------------------------------
// Box region density lookup unit
// Table of axis-aligned boxes searched for the first box that holds a point.
// ----------------------------------------------------------------------------
// Bound writes, density writes and query coordinates without the last mark
// never make the unit busy and give no result. A query coordinate with the
// last mark starts a scan of the boxes in use: one box is read from the bound
// memories and checked in all dimensions in use per cycle, and the scan stops
// at the first match or after the last box in use. When no boxes are in use
// the miss result is shown in the next cycle without a scan. Busy is high
// while a scan runs. Results are shown for one cycle on done and cannot be
// held off.
// ----------------------------------------------------------------------------
module box_region_density_lookup_unit #(
  parameter int MAX_REGIONS = brdl_pkg::MAX_REGIONS_DEF,
  parameter int MAX_DIMS    = brdl_pkg::MAX_DIMS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  brdl_pkg::in_item_t                 item,
  output logic                               done,
  output brdl_pkg::out_item_t                result,
  input  logic                               cfg_we,
  input  logic [brdl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [brdl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int DW = $clog2(MAX_DIMS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state;

  logic [6:0] region_count;
  logic [2:0] dim_count;

  logic signed [31:0] qp [MAX_DIMS];
  logic signed [31:0] lo_rdata [MAX_DIMS];
  logic signed [31:0] hi_rdata [MAX_DIMS];
  logic [30:0]        dens_rdata;

  logic          accept;
  logic          region_ok;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          issue_on;
  logic          issue_last;
  logic          chk_valid;
  logic          chk_last;
  logic [AW-1:0] chk_idx;
  logic [CW-1:0] nreg;
  logic [CW-1:0] nreg_next;
  logic [DW-1:0] ndim;
  logic [DW-1:0] ndim_next;
  logic          hit;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign region_ok = (32'(item.region_index) < MAX_REGIONS);
  assign wr_addr   = AW'(item.region_index);
  assign rd_en     = (state == ST_SCAN) && issue_on;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
      dim_count    <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brdl_pkg::REG_REGION_COUNT: region_count <= cfg_data;
        brdl_pkg::REG_DIM_COUNT:    dim_count    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Clamp the counts to the table size when a scan starts; a zero dimension count becomes one.
  always_comb begin
    if (32'(region_count) > MAX_REGIONS) begin
      nreg_next = CW'(MAX_REGIONS);
    end else begin
      nreg_next = CW'(region_count);
    end
    if (dim_count == 3'd0) begin
      ndim_next = DW'(1);
    end else if (32'(dim_count) > MAX_DIMS) begin
      ndim_next = DW'(MAX_DIMS);
    end else begin
      ndim_next = DW'(dim_count);
    end
  end

  // Per-dimension bound memories and query coordinate registers.
  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    logic bound_we;

    assign bound_we = accept && (item.mode == brdl_pkg::MODE_BOUNDS) && region_ok
                      && (32'(item.dim_index) == d);

    brdl_ram #(
      .WIDTH(32),
      .DEPTH(MAX_REGIONS)
    ) u_lo_ram (
      .clk  (clk),
      .we   (bound_we),
      .waddr(wr_addr),
      .wdata(item.low_bound),
      .re   (rd_en),
      .raddr(rd_addr),
      .rdata(lo_rdata[d])
    );

    brdl_ram #(
      .WIDTH(32),
      .DEPTH(MAX_REGIONS)
    ) u_hi_ram (
      .clk  (clk),
      .we   (bound_we),
      .waddr(wr_addr),
      .wdata(item.high_bound),
      .re   (rd_en),
      .raddr(rd_addr),
      .rdata(hi_rdata[d])
    );

    always_ff @(posedge clk) begin
      if (accept && (item.mode == brdl_pkg::MODE_QUERY) && (32'(item.dim_index) == d)) begin
        qp[d] <= item.coordinate;
      end
    end
  end

  brdl_ram #(
    .WIDTH(31),
    .DEPTH(MAX_REGIONS)
  ) u_dens_ram (
    .clk  (clk),
    .we   (accept && (item.mode == brdl_pkg::MODE_DENSITY) && region_ok),
    .waddr(wr_addr),
    .wdata(item.density_value),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(dens_rdata)
  );

  // The box whose bounds just came out of the memories holds the point when
  // every dimension in use satisfies low < x <= high.
  always_comb begin
    hit = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      if ((32'(ndim) > d) && !((qp[d] > lo_rdata[d]) && (qp[d] <= hi_rdata[d]))) begin
        hit = 1'b0;
      end
    end
  end

  assign issue_last = ((CW'(rd_addr) + CW'(1)) == nreg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      issue_on  <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (item.mode == brdl_pkg::MODE_QUERY) && item.last_coordinate) begin
            nreg <= nreg_next;
            ndim <= ndim_next;
            if (nreg_next == '0) begin
              done                  <= 1'b1;
              result.found          <= 1'b0;
              result.matched_region <= '0;
              result.density        <= brdl_pkg::NONE_DENSITY;
            end else begin
              done      <= 1'b0;
              state     <= ST_SCAN;
              rd_addr   <= '0;
              issue_on  <= 1'b1;
              chk_valid <= 1'b0;
            end
          end else begin
            done <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (chk_valid && hit) begin
            state                 <= ST_IDLE;
            done                  <= 1'b1;
            issue_on              <= 1'b0;
            chk_valid             <= 1'b0;
            result.found          <= 1'b1;
            result.matched_region <= 6'(chk_idx);
            result.density        <= {1'b0, dens_rdata};
          end else if (chk_valid && chk_last) begin
            state                 <= ST_IDLE;
            done                  <= 1'b1;
            issue_on              <= 1'b0;
            chk_valid             <= 1'b0;
            result.found          <= 1'b0;
            result.matched_region <= '0;
            result.density        <= brdl_pkg::NONE_DENSITY;
          end else begin
            done      <= 1'b0;
            chk_valid <= issue_on;
            chk_idx   <= rd_addr;
            chk_last  <= issue_last;
            if (issue_on) begin
              issue_on <= !issue_last;
              if (!issue_last) begin
                rd_addr <= rd_addr + AW'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- verif/box_region_density_lookup_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box region density lookup unit testbench
// Loads box bounds and densities, sends query points one coordinate at a time
// under several region and dimension counts, and compares every lookup result
// with a predictor that tracks the box table, the query point and the counts.
// ----------------------------------------------------------------------------
module box_region_density_lookup_unit_tb;

  localparam int NREG            = brdl_pkg::MAX_REGIONS_DEF;
  localparam int NDIM            = brdl_pkg::MAX_DIMS_DEF;
  localparam int STALL_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int NUM_PHASES      = 9;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int PHASE_REGIONS [NUM_PHASES] = '{64, 127, 1, 65, 32, 0, 64, 17, 100};
  localparam int PHASE_DIMS    [NUM_PHASES] = '{4, 2, 1, 0, 7, 3, 5, 4, 1};

  class box_lookup_scoreboard;
    logic signed [31:0]  low_tab  [NREG][NDIM];
    logic signed [31:0]  high_tab [NREG][NDIM];
    logic [30:0]         dens_tab [NREG];
    logic signed [31:0]  point    [NDIM];
    int unsigned         region_cfg;
    int unsigned         dim_cfg;
    brdl_pkg::out_item_t pending_lookups [$];
    int unsigned         errors;

    function new();
      region_cfg = 0;
      dim_cfg    = 1;
      errors     = 0;
    endfunction

    function void set_register(logic [brdl_pkg::CFG_INDEX_W-1:0] idx,
                               logic [brdl_pkg::CFG_DATA_W-1:0] data);
      if (idx == brdl_pkg::REG_REGION_COUNT) region_cfg = 32'(data);
      else if (idx == brdl_pkg::REG_DIM_COUNT) dim_cfg = 32'(data[2:0]);
    endfunction

    // First box, in index order, whose open-below, closed-above interval
    // holds the point in every dimension in use.
    function brdl_pkg::out_item_t predict_lookup();
      brdl_pkg::out_item_t res;
      int unsigned nreg, ndim;
      int r, d;
      bit contained;
      nreg = (region_cfg > NREG) ? NREG : region_cfg;
      ndim = (dim_cfg == 0) ? 1 : ((dim_cfg > NDIM) ? NDIM : dim_cfg);
      res.found          = 1'b0;
      res.matched_region = '0;
      res.density        = brdl_pkg::NONE_DENSITY;
      for (r = 0; r < nreg; r++) begin
        contained = 1'b1;
        for (d = 0; d < ndim; d++)
          if (point[d] <= low_tab[r][d] || point[d] > high_tab[r][d]) contained = 1'b0;
        if (contained) begin
          res.found          = 1'b1;
          res.matched_region = r[5:0];
          res.density        = {1'b0, dens_tab[r]};
          return res;
        end
      end
      return res;
    endfunction

    function void note_item(brdl_pkg::in_item_t it);
      case (it.mode)
        brdl_pkg::MODE_BOUNDS: begin
          low_tab[it.region_index][it.dim_index]  = it.low_bound;
          high_tab[it.region_index][it.dim_index] = it.high_bound;
        end
        brdl_pkg::MODE_DENSITY: dens_tab[it.region_index] = it.density_value;
        brdl_pkg::MODE_QUERY: begin
          point[it.dim_index] = it.coordinate;
          if (it.last_coordinate) pending_lookups = {pending_lookups, predict_lookup()};
        end
        default: ;
      endcase
    endfunction

    function void check_result(brdl_pkg::out_item_t got);
      brdl_pkg::out_item_t want;
      if (pending_lookups.size() == 0) begin
        $error("result with no lookup pending: found=%0d region=%0d density=%h",
               got.found, got.matched_region, got.density);
        errors++;
        return;
      end
      want = pending_lookups.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.matched_region !== want.matched_region) begin
        $error("matched_region: expected %0d, actual %0d",
               want.matched_region, got.matched_region);
        errors++;
      end
      if (got.density !== want.density) begin
        $error("density: expected %h, actual %h", want.density, got.density);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst       = 1'b1;
  logic                             start     = 1'b0;
  logic                             busy;
  brdl_pkg::in_item_t               item      = '0;
  logic                             done;
  brdl_pkg::out_item_t              result;
  logic                             cfg_we    = 1'b0;
  logic [brdl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [brdl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  box_lookup_scoreboard sb = new();
  int unsigned burst_left   = 0;
  int unsigned stall_cycles = 0;

  box_region_density_lookup_unit uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // A result at the same edge as a new item always belongs to an older one,
  // so it is checked first.
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) sb.check_result(result);
      if (start && !busy) sb.note_item(item);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL box_region_density_lookup_unit");
        $finish;
      end
    end
  end

  // Mostly within +/-16.0 so that boxes and points overlap often.
  function automatic logic signed [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(0, 19))
      0: v = $urandom;
      1: v = 32'h8000_0000;
      2: v = 32'h7FFF_FFFF;
      default: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
    return v;
  endfunction

  function automatic brdl_pkg::in_item_t noise_item();
    brdl_pkg::in_item_t it;
    it.mode            = 2'($urandom);
    it.region_index    = 6'($urandom);
    it.dim_index       = 2'($urandom);
    it.low_bound       = $urandom;
    it.high_bound      = $urandom;
    it.density_value   = 31'($urandom);
    it.coordinate      = $urandom;
    it.last_coordinate = 1'($urandom);
    return it;
  endfunction

  function automatic brdl_pkg::in_item_t bounds_item(logic [5:0] r, logic [1:0] d,
                                                     logic signed [31:0] lo,
                                                     logic signed [31:0] hi);
    brdl_pkg::in_item_t it;
    it              = noise_item();
    it.mode         = brdl_pkg::MODE_BOUNDS;
    it.region_index = r;
    it.dim_index    = d;
    it.low_bound    = lo;
    it.high_bound   = hi;
    return it;
  endfunction

  function automatic brdl_pkg::in_item_t random_box_item(logic [5:0] r, logic [1:0] d);
    logic signed [31:0] lo, hi;
    lo = pick_coord();
    hi = lo + $urandom_range(0, 32'h0018_0000);
    if ($urandom_range(0, 9) == 0) hi = pick_coord();
    return bounds_item(r, d, lo, hi);
  endfunction

  function automatic brdl_pkg::in_item_t density_item(logic [5:0] r, logic [30:0] v);
    brdl_pkg::in_item_t it;
    it               = noise_item();
    it.mode          = brdl_pkg::MODE_DENSITY;
    it.region_index  = r;
    it.density_value = v;
    return it;
  endfunction

  function automatic brdl_pkg::in_item_t coord_item(logic [1:0] d, logic signed [31:0] x,
                                                    logic last);
    brdl_pkg::in_item_t it;
    it                 = noise_item();
    it.mode            = brdl_pkg::MODE_QUERY;
    it.dim_index       = d;
    it.coordinate      = x;
    it.last_coordinate = last;
    return it;
  endfunction

  // Start stays high across a burst; a gap with start low follows it.
  task automatic push_item(input brdl_pkg::in_item_t it);
    int unsigned gap;
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_lookups();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_lookups.size() != 0 || busy !== 1'b0) @(posedge clk);
    // Writes and non-final coordinates give no result; let them settle.
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input int unsigned regions, input int unsigned dims);
    logic [brdl_pkg::CFG_DATA_W-1:0] dim_word;
    dim_word  = {4'($urandom_range(0, 15)), 3'(dims)};
    cfg_we    <= 1'b1;
    cfg_index <= brdl_pkg::REG_REGION_COUNT;
    cfg_data  <= brdl_pkg::CFG_DATA_W'(regions);
    @(posedge clk);
    sb.set_register(brdl_pkg::REG_REGION_COUNT, brdl_pkg::CFG_DATA_W'(regions));
    cfg_index <= brdl_pkg::REG_DIM_COUNT;
    cfg_data  <= dim_word;
    @(posedge clk);
    sb.set_register(brdl_pkg::REG_DIM_COUNT, dim_word);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    brdl_pkg::in_item_t it;
    int unsigned        counted, pick, npts, p, k, r, d;
    logic               last;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With no boxes in use the lookup misses without reading the table.
    push_item(coord_item(2'd0, 32'sh0000_1234, 1'b1));
    drain_lookups();
    configure(2, 1);

    // Box 0 is (0, 1.0]; box 1 spans the whole range except the minimum.
    push_item(bounds_item(6'd0, 2'd0, 32'sh0000_0000, 32'sh0001_0000));
    push_item(bounds_item(6'd1, 2'd0, 32'sh8000_0000, 32'sh7FFF_FFFF));
    push_item(density_item(6'd0, 31'd0));
    push_item(density_item(6'd1, 31'h7FFF_FFFF));
    push_item(coord_item(2'd0, 32'sh0001_0000, 1'b1));
    push_item(coord_item(2'd0, 32'sh0000_0000, 1'b1));
    push_item(coord_item(2'd0, 32'sh0000_0001, 1'b1));
    push_item(coord_item(2'd0, 32'sh8000_0000, 1'b1));
    push_item(coord_item(2'd0, 32'sh7FFF_FFFF, 1'b1));
    // A coordinate outside the dimensions in use still ends the point.
    push_item(coord_item(2'd0, 32'sh0000_8000, 1'b0));
    push_item(coord_item(2'd3, $urandom, 1'b1));
    it      = noise_item();
    it.mode = MODE_UNUSED;
    push_item(it);
    // An inverted box never holds a point.
    push_item(bounds_item(6'd0, 2'd0, 32'sh0001_0000, 32'sh0000_0000));
    push_item(coord_item(2'd0, 32'sh0000_8000, 1'b1));

    // Every box and every point coordinate is written before wider scans.
    for (r = 0; r < NREG; r++)
      for (d = 0; d < NDIM; d++)
        push_item(random_box_item(6'(r), 2'(d)));
    for (r = 0; r < NREG; r++) push_item(density_item(6'(r), 31'($urandom)));
    for (d = 0; d < NDIM; d++) push_item(coord_item(2'(d), pick_coord(), 1'b0));

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_lookups();
      configure(PHASE_REGIONS[p], PHASE_DIMS[p]);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          it      = noise_item();
          it.mode = MODE_UNUSED;
          push_item(it);
        end else if (pick < 20) begin
          push_item(random_box_item(6'($urandom), 2'($urandom)));
          counted++;
        end else if (pick < 28) begin
          push_item(density_item(6'($urandom), 31'($urandom)));
          counted++;
        end else begin
          // A point sent as a few coordinates, now and then with the last
          // mark misplaced.
          npts = $urandom_range(1, 4);
          for (k = 0; k < npts; k++) begin
            last = (k == npts - 1) ^ ($urandom_range(0, 9) == 0);
            push_item(coord_item(2'($urandom), pick_coord(), last));
            counted++;
          end
        end
      end
    end

    drain_lookups();
    repeat (70) @(posedge clk);
    if (sb.pending_lookups.size() != 0) begin
      $error("%0d lookup results never arrived", sb.pending_lookups.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS box_region_density_lookup_unit");
    end else begin
      $display("FAIL box_region_density_lookup_unit");
    end
    $finish;
  end

endmodule
